[rtl/lcd_seq_pkg.sv]
// Shared types, codes and command tables for the character LCD bus sequencer.
package lcd_seq_pkg;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_CMD   = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_POS   = 3'd3;
    localparam logic [2:0] OP_GLYPH = 3'd4;

    localparam logic CFG_IDX_MODE = 1'b0;

    localparam logic [3:0] STEP_CGRAM     = 4'd0;
    localparam logic [3:0] STEP_ROW_LAST  = 4'd8;
    localparam logic [3:0] STEP_INIT_LAST = 4'd8;
    localparam logic [3:0] STEP_CURSOR    = 4'd9;
    localparam logic [3:0] STEP_DATA      = 4'd10;

    localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
    localparam logic [7:0] CMD_FUNC_4BIT = 8'h28;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_LINE1     = 8'h80;

    localparam logic [7:0] ROW_BASE_1 = 8'h80;
    localparam logic [7:0] ROW_BASE_2 = 8'hC0;
    localparam logic [7:0] ROW_BASE_3 = 8'h94;
    localparam logic [7:0] ROW_BASE_4 = 8'hD4;

    localparam logic [14:0] WAIT_FIRST  = 15'd20000;
    localparam logic [14:0] WAIT_SECOND = 15'd5000;
    localparam logic [14:0] WAIT_THIRD  = 15'd150;
    localparam logic [14:0] WAIT_NONE   = 15'd0;

    typedef enum logic [2:0] {
        KIND_INIT,
        KIND_CMD,
        KIND_DATA,
        KIND_POS,
        KIND_GLYPH
    } kind_t;

    typedef enum logic {
        BK_START,
        BK_RUN
    } bk_state_t;

    typedef struct packed {
        kind_t       kind;
        logic        four_bit;
        logic [7:0]  byte_value;
        logic        pos_valid;
        logic [7:0]  cursor_addr;
        logic [2:0]  slot;
        logic [63:0] glyph_rows;
    } desc_t;

    function automatic logic [7:0] init_byte(input logic [3:0] step, input logic four_bit);
        logic [7:0] b;
        case (step)
            4'd0, 4'd1, 4'd2: b = CMD_FUNC_8BIT;
            4'd3:             b = CMD_CLEAR;
            4'd4:             b = CMD_HOME;
            4'd5:             b = CMD_ENTRY;
            4'd6:             b = CMD_DISP_ON;
            4'd7:             b = four_bit ? CMD_FUNC_4BIT : CMD_FUNC_8BIT;
            default:          b = CMD_LINE1;
        endcase
        return b;
    endfunction

    function automatic logic [14:0] init_wait(input logic [3:0] step);
        logic [14:0] w;
        case (step)
            4'd0:    w = WAIT_FIRST;
            4'd1:    w = WAIT_SECOND;
            4'd2:    w = WAIT_THIRD;
            default: w = WAIT_NONE;
        endcase
        return w;
    endfunction

endpackage

[rtl/lcd_seq_if.sv]
// Request and transfer channel interfaces of the character LCD bus sequencer.
interface lcd_seq_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [7:0]  byte_value;
    logic [2:0]  row;
    logic [5:0]  column;
    logic [2:0]  glyph_slot;
    logic [63:0] glyph_rows;

    modport source (
        output valid, opcode, byte_value, row, column, glyph_slot, glyph_rows,
        input  ready
    );
    modport sink (
        input  valid, opcode, byte_value, row, column, glyph_slot, glyph_rows,
        output ready
    );
endinterface

interface lcd_seq_xfer_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [7:0]  bus_value;
    logic [14:0] wait_before_us;
    logic        last;

    modport source (
        output valid, reg_select, bus_value, wait_before_us, last,
        input  ready
    );
    modport sink (
        input  valid, reg_select, bus_value, wait_before_us, last,
        output ready
    );
endinterface

[rtl/lcd_seq_front.sv]
// Request front end: mode register, request decode and cursor address calculation.
module lcd_seq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    lcd_seq_req_if.sink          req,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output logic                 push,
    output lcd_seq_pkg::desc_t   push_desc,
    input  logic                 q_full
);

    logic       mode_reg;
    logic       mode_next;
    logic       op_valid;
    logic [7:0] row_base;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == lcd_seq_pkg::CFG_IDX_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && (paddr[2] == lcd_seq_pkg::CFG_IDX_MODE))
        begin
            mode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        push_desc.pos_valid = 1'b1;
        unique case (req.row)
            3'd1:    row_base = lcd_seq_pkg::ROW_BASE_1;
            3'd2:    row_base = lcd_seq_pkg::ROW_BASE_2;
            3'd3:    row_base = lcd_seq_pkg::ROW_BASE_3;
            3'd4:    row_base = lcd_seq_pkg::ROW_BASE_4;
            default:
            begin
                row_base            = 8'd0;
                push_desc.pos_valid = 1'b0;
            end
        endcase
        push_desc.cursor_addr = row_base + {2'b00, req.column} + 8'hFF;
        push_desc.four_bit    = mode_reg;
        push_desc.byte_value  = req.byte_value;
        push_desc.slot        = req.glyph_slot;
        push_desc.glyph_rows  = req.glyph_rows;
        op_valid              = 1'b1;
        unique case (req.opcode)
            lcd_seq_pkg::OP_INIT:  push_desc.kind = lcd_seq_pkg::KIND_INIT;
            lcd_seq_pkg::OP_CMD:   push_desc.kind = lcd_seq_pkg::KIND_CMD;
            lcd_seq_pkg::OP_DATA:  push_desc.kind = lcd_seq_pkg::KIND_DATA;
            lcd_seq_pkg::OP_POS:   push_desc.kind = lcd_seq_pkg::KIND_POS;
            lcd_seq_pkg::OP_GLYPH: push_desc.kind = lcd_seq_pkg::KIND_GLYPH;
            default:
            begin
                push_desc.kind = lcd_seq_pkg::KIND_CMD;
                op_valid       = 1'b0;
            end
        endcase
    end

    // Requests with an unused opcode are taken and dropped.
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full && op_valid;

endmodule

[rtl/lcd_seq_queue.sv]
// Small request queue between the front end and the transfer sequencer.
module lcd_seq_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lcd_seq_pkg::desc_t   push_desc,
    input  logic                 pop,
    output lcd_seq_pkg::desc_t   head,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcd_seq_pkg::desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/lcd_seq_back.sv]
// Transfer sequencer: expands a request into bus words, one per cycle while xfer is ready.
module lcd_seq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcd_seq_pkg::desc_t   head,
    input  logic                 q_empty,
    output logic                 pop,
    lcd_seq_xfer_if.source       xfer
);

    lcd_seq_pkg::bk_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        nib_reg, nib_next;
    logic [3:0]  start_step;
    logic [3:0]  cur_step;
    logic [3:0]  after_step;
    logic [2:0]  row_idx;
    logic [7:0]  cur_byte;
    logic        cur_rs;
    logic        issue;
    logic        last_byte;
    logic        last_xfer;
    logic        out_valid_reg, out_valid_next;
    logic        rs_reg, rs_next;
    logic [7:0]  bus_reg, bus_next;
    logic [14:0] wait_reg, wait_next;
    logic        last_reg, last_next;

    always_comb
    begin
        unique case (head.kind) inside
            lcd_seq_pkg::KIND_INIT, lcd_seq_pkg::KIND_GLYPH:
                start_step = lcd_seq_pkg::STEP_CGRAM;
            lcd_seq_pkg::KIND_POS:
                start_step = head.pos_valid ? lcd_seq_pkg::STEP_CURSOR
                                            : lcd_seq_pkg::STEP_DATA;
            default:
                start_step = lcd_seq_pkg::STEP_DATA;
        endcase
    end

    assign cur_step = (state_reg == lcd_seq_pkg::BK_RUN) ? step_reg : start_step;
    assign row_idx  = 3'(cur_step - 4'd1);
    assign issue    = !q_empty && (!out_valid_reg || xfer.ready);

    always_comb
    begin
        cur_rs   = 1'b1;
        cur_byte = head.glyph_rows[{row_idx, 3'b000} +: 8];
        if (head.kind == lcd_seq_pkg::KIND_INIT)
        begin
            cur_rs   = 1'b0;
            cur_byte = lcd_seq_pkg::init_byte(cur_step, head.four_bit);
        end
        else
        begin
            case (cur_step)
                lcd_seq_pkg::STEP_CGRAM:
                begin
                    cur_rs   = 1'b0;
                    cur_byte = {2'b01, head.slot, 3'b000};
                end
                lcd_seq_pkg::STEP_CURSOR:
                begin
                    cur_rs   = 1'b0;
                    cur_byte = head.cursor_addr;
                end
                lcd_seq_pkg::STEP_DATA:
                begin
                    cur_rs   = (head.kind != lcd_seq_pkg::KIND_CMD);
                    cur_byte = (head.kind == lcd_seq_pkg::KIND_GLYPH) ? {5'd0, head.slot}
                                                                       : head.byte_value;
                end
                default:
                begin
                    cur_rs   = 1'b1;
                    cur_byte = head.glyph_rows[{row_idx, 3'b000} +: 8];
                end
            endcase
        end
    end

    assign last_byte = (head.kind == lcd_seq_pkg::KIND_INIT)
                       ? (cur_step == lcd_seq_pkg::STEP_INIT_LAST)
                       : (cur_step == lcd_seq_pkg::STEP_DATA);
    assign last_xfer = last_byte && (!head.four_bit || nib_reg);

    // After the last pattern byte of a glyph, the cursor command is skipped for an invalid row.
    assign after_step = ((head.kind != lcd_seq_pkg::KIND_INIT)
                         && (cur_step == lcd_seq_pkg::STEP_ROW_LAST))
                        ? (head.pos_valid ? lcd_seq_pkg::STEP_CURSOR : lcd_seq_pkg::STEP_DATA)
                        : cur_step + 4'd1;

    always_comb
    begin
        state_next = state_reg;
        if (issue)
        begin
            state_next = last_xfer ? lcd_seq_pkg::BK_START : lcd_seq_pkg::BK_RUN;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        nib_next       = nib_reg;
        pop            = issue && last_xfer;
        out_valid_next = xfer.ready ? 1'b0 : out_valid_reg;
        rs_next        = rs_reg;
        bus_next       = bus_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            rs_next        = cur_rs;
            last_next      = last_xfer;
            if (head.four_bit)
            begin
                bus_next = nib_reg ? {4'd0, cur_byte[3:0]} : {4'd0, cur_byte[7:4]};
            end
            else
            begin
                bus_next = cur_byte;
            end
            if (nib_reg || (head.kind != lcd_seq_pkg::KIND_INIT))
            begin
                wait_next = lcd_seq_pkg::WAIT_NONE;
            end
            else
            begin
                wait_next = lcd_seq_pkg::init_wait(cur_step);
            end
            if (last_xfer)
            begin
                nib_next  = 1'b0;
                step_next = lcd_seq_pkg::STEP_CGRAM;
            end
            else if (head.four_bit && !nib_reg)
            begin
                nib_next  = 1'b1;
                step_next = cur_step;
            end
            else
            begin
                nib_next  = 1'b0;
                step_next = after_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcd_seq_pkg::BK_START;
            step_reg      <= lcd_seq_pkg::STEP_CGRAM;
            nib_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nib_reg       <= nib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        bus_reg  <= bus_next;
        wait_reg <= wait_next;
        last_reg <= last_next;
    end

    assign xfer.valid          = out_valid_reg;
    assign xfer.reg_select     = rs_reg;
    assign xfer.bus_value      = bus_reg;
    assign xfer.wait_before_us = wait_reg;
    assign xfer.last           = last_reg;

`ifndef SYNTHESIS
    a_run_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcd_seq_pkg::BK_RUN) |-> !q_empty)
        else $error("sequencer running without a queued request");

    a_nibble_mode: assert property (@(posedge clk) disable iff (!rst_n)
        nib_reg |-> ((state_reg == lcd_seq_pkg::BK_RUN) && head.four_bit))
        else $error("low nibble pending outside a 4-bit request");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcd_seq_pkg::BK_RUN) |-> (step_reg <= lcd_seq_pkg::STEP_DATA))
        else $error("sequencer step out of range");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (xfer.valid && xfer.last))
        else $error("request retired without a final word");
`endif

endmodule

[rtl/char_lcd_bus_sequencer.sv]
// Top level of the character LCD bus sequencer: front end, request queue and sequencer.
// With the sequencer idle, a request is written into the queue and its first word is then
// registered at the sequencer output. Throughput: one bus word per cycle while xfer.ready
// is high; a request has 1 to 22 words (22 for a custom glyph on the 4-bit bus).
// The front end keeps taking requests while the queue has room.
// Reset (rst_n low, asynchronous): 4-bit mode selected, queue empty, no word pending.
module char_lcd_bus_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    lcd_seq_req_if.sink   req,
    lcd_seq_xfer_if.source xfer,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    lcd_seq_pkg::desc_t push_desc;
    lcd_seq_pkg::desc_t head;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    lcd_seq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full)
    );

    lcd_seq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    lcd_seq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .xfer    (xfer)
    );

endmodule
